/* src/framebuffer_scanout_pixel_converter_core_defines.svh */
// Assertion macros shared by the scan-out pixel converter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FRAMEBUFFER_SCANOUT_PIXEL_CONVERTER_CORE_DEFINES_SVH
`define FRAMEBUFFER_SCANOUT_PIXEL_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define FSPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define FSPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fspc_pkg.sv */
// Shared constants, types and helper functions of the scan-out pixel converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package fspc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BITS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_HEIGHT = 3'd4;

    // Destination depths that produce writes
    localparam logic [5:0] BPP_8  = 6'd8;
    localparam logic [5:0] BPP_16 = 6'd16;
    localparam logic [5:0] BPP_24 = 6'd24;
    localparam logic [5:0] BPP_32 = 6'd32;

    // Byte counts of a write; none marks an unsupported depth
    localparam logic [2:0] BYTES_NONE = 3'd0;
    localparam logic [2:0] BYTES_1    = 3'd1;
    localparam logic [2:0] BYTES_2    = 3'd2;
    localparam logic [2:0] BYTES_3    = 3'd3;
    localparam logic [2:0] BYTES_4    = 3'd4;

    // Converted pixel and its size
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  bytes;
    } t_conv;

    // (r+g+b)/48: divide by 16 with a shift, then by 3 via x*43>>7 (exact for x < 48)
    function automatic logic [7:0] grey_of(input logic [31:0] color);
        logic [9:0]  sum;
        logic [5:0]  sixteenths;
        logic [11:0] prod;
        sum        = 10'(color[23:16]) + 10'(color[15:8]) + 10'(color[7:0]);
        sixteenths = sum[9:4];
        prod       = 12'(sixteenths) * 12'd43;
        return {3'b000, prod[11:7]};
    endfunction

endpackage

`default_nettype wire

/* src/fspc_conv.sv */
// Pixel format conversion: xRGB8888 source pixel to the destination depth.
// Depends on fspc_pkg for depth codes, byte counts and the grey divider.
`default_nettype none

module fspc_conv
    import fspc_pkg::*;
(
    input  wire logic [31:0] i_pixel_color,
    input  wire logic [5:0]  i_pixel_bits,
    output t_conv            o_conv
);

    always_comb begin
        unique case (i_pixel_bits)
            BPP_32: begin
                o_conv.data  = i_pixel_color;
                o_conv.bytes = BYTES_4;
            end
            BPP_24: begin
                o_conv.data  = {8'h00, i_pixel_color[23:0]};
                o_conv.bytes = BYTES_3;
            end
            BPP_16: begin
                // RGB565
                o_conv.data  = {16'h0000, i_pixel_color[23:19], i_pixel_color[15:10],
                                i_pixel_color[7:3]};
                o_conv.bytes = BYTES_2;
            end
            BPP_8: begin
                o_conv.data  = {24'h000000, grey_of(i_pixel_color)};
                o_conv.bytes = BYTES_1;
            end
            default: begin
                o_conv.data  = '0;
                o_conv.bytes = BYTES_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/fspc_pos.sv */
// Raster position tracker: column and row counters over the source frame.
// Depends on fspc_pkg (wildcard import) and the shared assertion macros.
`default_nettype none
`include "framebuffer_scanout_pixel_converter_core_defines.svh"

module fspc_pos
    import fspc_pkg::*;
#(
    parameter int unsigned SRC_WIDTH  = 800,
    parameter int unsigned SRC_HEIGHT = 600,
    parameter int unsigned CW         = 10,
    parameter int unsigned RW         = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_advance,
    input  wire logic          i_frame_start,
    output logic      [CW-1:0] o_col,
    output logic      [RW-1:0] o_row
);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          last_col;
    logic          last_row;

    // position of the item being taken; frame start restarts at the origin
    assign o_col    = i_frame_start ? '0 : r_col;
    assign o_row    = i_frame_start ? '0 : r_row;
    assign last_col = (o_col == CW'(SRC_WIDTH - 1));
    assign last_row = (o_row == RW'(SRC_HEIGHT - 1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : o_row + RW'(1);
            end else begin
                n_col = o_col + CW'(1);
                n_row = o_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `FSPC_ASSERT_NOW(a_col_in_range, 1'b1, 32'(r_col) < SRC_WIDTH, "column beyond source width")
    `FSPC_ASSERT_NOW(a_row_in_range, 1'b1, 32'(r_row) < SRC_HEIGHT, "row beyond source height")
    `FSPC_ASSERT_NEXT(a_hold_when_idle, !i_advance, $stable(r_col) && $stable(r_row),
                      "position moved without an item")

endmodule

`default_nettype wire

/* src/framebuffer_scanout_pixel_converter_core.sv */
// Scan-out pixel converter: turns a raster stream of xRGB8888 pixels from a
// SRC_WIDTH x SRC_HEIGHT back buffer into clipped destination framebuffer
// writes (address, data, byte count, end-of-frame flag) at 8, 16, 24 or 32 bpp.
// Throughput is one item per clock with no bubbles while the output is not
// stalled; a write passes the input register, then the result register, on
// its way to the output. The clock rate is set by the row * pitch multiply
// (10 x 16) and the three-term address add that follows it after the input
// register. Pixels outside the visible window, or any pixel while a setting is
// zero or the depth is unsupported, advance the position but give no write.
// The user must write configuration only while the block is idle; the block
// itself does not enforce this. dest_base and row_pitch feed the address
// arithmetic directly, so a change also applies to an item in the input register.
// Depends on fspc_pkg, fspc_pos, fspc_conv and the shared assertion macros.
`default_nettype none
`include "framebuffer_scanout_pixel_converter_core_defines.svh"

module framebuffer_scanout_pixel_converter_core
    import fspc_pkg::*;
#(
    parameter int unsigned SRC_WIDTH  = 800,
    parameter int unsigned SRC_HEIGHT = 600
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    // source pixel items
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [31:0]          i_pixel_color,
    input  wire logic                 i_frame_start,
    // destination write items
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [31:0]          o_write_address,
    output logic      [31:0]          o_write_data,
    output logic      [2:0]           o_byte_count,
    output logic                      o_frame_last
);

    // counter widths; a one-pixel dimension still keeps a one-bit counter
    localparam int unsigned CW = (SRC_WIDTH  > 1) ? $clog2(SRC_WIDTH)  : 1;
    localparam int unsigned RW = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam int unsigned PW = RW + 16;   // row * pitch product
    localparam int unsigned OW = CW + 2;    // column * bytes offset

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [31:0] r_dest_base;
    logic [15:0] r_row_pitch;
    logic [5:0]  r_pixel_bits;
    logic [15:0] r_visible_width;
    logic [15:0] r_visible_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_base      <= '0;
            r_row_pitch      <= '0;
            r_pixel_bits     <= '0;
            r_visible_width  <= '0;
            r_visible_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEST_BASE:      r_dest_base      <= i_cfg_data;
                CFG_ROW_PITCH:      r_row_pitch      <= i_cfg_data[15:0];
                CFG_PIXEL_BITS:     r_pixel_bits     <= i_cfg_data[5:0];
                CFG_VISIBLE_WIDTH:  r_visible_width  <= i_cfg_data[15:0];
                CFG_VISIBLE_HEIGHT: r_visible_height <= i_cfg_data[15:0];
                default: ;          // unknown index: ignored
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: the input register refills whenever it is empty or its
    // item moves on this cycle, so a stalled result blocks intake only while it is full.
    // ---------------------------------------------------------------------
    logic r_s1_vld;
    logic r_out_vld;
    logic out_ready;
    logic s1_ready;
    logic in_acc;
    logic s1_hit;

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign s1_ready   = !r_s1_vld || out_ready;
    assign in_acc     = i_in_valid && s1_ready;
    assign o_in_stall = !s1_ready;

    // ---------------------------------------------------------------------
    // Cycle 1: raster position and input register
    // ---------------------------------------------------------------------
    logic [CW-1:0] pos_col;
    logic [RW-1:0] pos_row;

    fspc_pos #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (in_acc),
        .i_frame_start (i_frame_start),
        .o_col         (pos_col),
        .o_row         (pos_row)
    );

    logic [31:0]   r_s1_color;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_color <= i_pixel_color;
            r_s1_col   <= pos_col;
            r_s1_row   <= pos_row;
        end
    end

    // ---------------------------------------------------------------------
    // Cycle 2: clip, convert, address
    // ---------------------------------------------------------------------
    t_conv         conv;
    logic [15:0]   clip_w;
    logic [15:0]   clip_h;
    logic          setup_ok;
    logic          in_window;
    logic          last_pix;
    logic [PW-1:0] row_off;
    logic [OW-1:0] col_off;
    logic [31:0]   addr;

    fspc_conv u_conv (
        .i_pixel_color (r_s1_color),
        .i_pixel_bits  (r_pixel_bits),
        .o_conv        (conv)
    );

    // visible window clipped to the source frame
    assign clip_w = (r_visible_width  < 16'(SRC_WIDTH))  ? r_visible_width  : 16'(SRC_WIDTH);
    assign clip_h = (r_visible_height < 16'(SRC_HEIGHT)) ? r_visible_height : 16'(SRC_HEIGHT);

    // every setting non-zero and a supported depth
    assign setup_ok  = (r_dest_base != '0) && (r_row_pitch != '0) && (r_pixel_bits != '0)
                    && (clip_w != '0) && (clip_h != '0) && (conv.bytes != BYTES_NONE);
    assign in_window = (16'(r_s1_col) < clip_w) && (16'(r_s1_row) < clip_h);
    assign s1_hit    = setup_ok && in_window;
    assign last_pix  = (16'(r_s1_col) == clip_w - 16'd1) && (16'(r_s1_row) == clip_h - 16'd1);

    assign row_off = PW'(r_s1_row) * PW'(r_row_pitch);

    // column * bytes per pixel by shift and add
    always_comb begin
        unique case (conv.bytes)
            BYTES_4: col_off = {r_s1_col, 2'b00};
            BYTES_3: col_off = OW'({r_s1_col, 1'b0}) + OW'(r_s1_col);
            BYTES_2: col_off = OW'({r_s1_col, 1'b0});
            default: col_off = OW'(r_s1_col);
        endcase
    end

    assign addr = r_dest_base + 32'(row_off) + 32'(col_off);

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= r_s1_vld && s1_hit;
        end
    end

    logic [31:0] r_write_address;
    logic [31:0] r_write_data;
    logic [2:0]  r_byte_count;
    logic        r_frame_last;

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_vld && s1_hit) begin
            r_write_address <= addr;
            r_write_data    <= conv.data;
            r_byte_count    <= conv.bytes;
            r_frame_last    <= last_pix;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_write_address = r_write_address;
    assign o_write_data    = r_write_data;
    assign o_byte_count    = r_byte_count;
    assign o_frame_last    = r_frame_last;

    `FSPC_ASSERT_NOW(a_count_legal, r_out_vld,
                     r_byte_count == BYTES_1 || r_byte_count == BYTES_2 ||
                     r_byte_count == BYTES_3 || r_byte_count == BYTES_4,
                     "write with illegal byte count")
    `FSPC_ASSERT_NOW(a_grey_narrow, r_out_vld && r_byte_count == BYTES_1,
                     r_write_data[31:8] == '0, "8 bpp write with high bits set")
    `FSPC_ASSERT_NOW(a_empty_takes, !r_s1_vld, !o_in_stall,
                     "input stalled with an empty input register")

endmodule

`default_nettype wire
